/* hw/rtl/imq_pkg.sv */
// ---------------------------------------------------------------------------
// imq_pkg: shared types for the indexed max-priority queue
// Action codes, controller command and datapath status structs.
// ---------------------------------------------------------------------------
package imq_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int ID_WIDTH         = 6;
   localparam int PRIO_WIDTH       = 32;
   localparam int COUNT_WIDTH      = 7;

   localparam logic [2:0] ACT_INSERT   = 3'd0;
   localparam logic [2:0] ACT_INCREASE = 3'd1;
   localparam logic [2:0] ACT_DECREASE = 3'd2;
   localparam logic [2:0] ACT_REMOVE   = 3'd3;
   localparam logic [2:0] ACT_QUERY    = 3'd4;

   // read port A address source
   typedef enum logic [2:0] {
      ASEL_POS,
      ASEL_ZERO,
      ASEL_LAST,
      ASEL_PARENT,
      ASEL_LEFT
   } asel_type;

   // how the pending result is formed
   typedef enum logic [1:0] {
      RES_NONE,
      RES_FAIL,
      RES_OK_PLAIN,
      RES_OK_MEM
   } res_type;

   typedef struct packed {
      logic     load_req;
      logic     ins_start;
      logic     pos_rd;
      logic     a_rd;
      asel_type a_sel;
      logic     b_rd;
      logic     latch_p_pos;
      logic     e_from_req;
      logic     e_from_a;
      logic     p_zero;
      logic     rm_top;
      logic     up_move;
      logic     dn_move;
      logic     place;
      res_type  res;
      logic     rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] act;
      logic       id_ok;
      logic       present;
      logic       count_zero;
      logic       count_full;
      logic       last_nonzero;
      logic       p_zero;
      logic       left_out;
      logic       up_gt;
      logic       dn_lt;
      logic       inc_ok;
      logic       dec_ok;
      logic       out_free;
   } status_type;

endpackage

/* hw/rtl/imq_ctrl.sv */
// ---------------------------------------------------------------------------
// imq_ctrl: sequencer for the indexed max-priority queue
// Decodes a request and walks the heap one level per iteration.
// ---------------------------------------------------------------------------
module imq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  imq_pkg::status_type status,
   output imq_pkg::cmd_type    cmd
);

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b00000000001,
      ST_DECODE  = 11'b00000000010,
      ST_POS_WT  = 11'b00000000100,
      ST_SLOT_WT = 11'b00000001000,
      ST_TOP_WT  = 11'b00000010000,
      ST_LAST_WT = 11'b00000100000,
      ST_UP_RD   = 11'b00001000000,
      ST_UP_CMP  = 11'b00010000000,
      ST_DN_RD   = 11'b00100000000,
      ST_DN_CMP  = 11'b01000000000,
      ST_FIN     = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.a_sel = imq_pkg::ASEL_ZERO;
      cmd.res   = imq_pkg::RES_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.act) inside
               imq_pkg::ACT_INSERT: begin
                  if (status.id_ok && !status.present && !status.count_full) begin
                     cmd.ins_start = 1'b1;
                     cmd.res       = imq_pkg::RES_OK_PLAIN;
                     state_in      = ST_UP_RD;
                  end else begin
                     cmd.res  = imq_pkg::RES_FAIL;
                     state_in = ST_FIN;
                  end
               end
               imq_pkg::ACT_INCREASE, imq_pkg::ACT_DECREASE, imq_pkg::ACT_QUERY: begin
                  if (status.present) begin
                     cmd.pos_rd = 1'b1;
                     state_in   = ST_POS_WT;
                  end else begin
                     cmd.res  = imq_pkg::RES_FAIL;
                     state_in = ST_FIN;
                  end
               end
               imq_pkg::ACT_REMOVE: begin
                  if (!status.count_zero) begin
                     cmd.a_rd  = 1'b1;
                     cmd.a_sel = imq_pkg::ASEL_ZERO;
                     state_in  = ST_TOP_WT;
                  end else begin
                     cmd.res  = imq_pkg::RES_FAIL;
                     state_in = ST_FIN;
                  end
               end
               default: begin
                  cmd.res  = imq_pkg::RES_FAIL;
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_POS_WT: begin
            cmd.latch_p_pos = 1'b1;
            cmd.a_rd        = 1'b1;
            cmd.a_sel       = imq_pkg::ASEL_POS;
            state_in        = ST_SLOT_WT;
         end
         ST_SLOT_WT: begin
            state_in = ST_FIN;
            if (status.act == imq_pkg::ACT_QUERY) begin
               cmd.res = imq_pkg::RES_OK_MEM;
            end else if (status.act == imq_pkg::ACT_INCREASE && status.inc_ok) begin
               cmd.e_from_req = 1'b1;
               cmd.res        = imq_pkg::RES_OK_PLAIN;
               state_in       = ST_UP_RD;
            end else if (status.act == imq_pkg::ACT_DECREASE && status.dec_ok) begin
               cmd.e_from_req = 1'b1;
               cmd.res        = imq_pkg::RES_OK_PLAIN;
               state_in       = ST_DN_RD;
            end else begin
               cmd.res = imq_pkg::RES_FAIL;
            end
         end
         ST_TOP_WT: begin
            cmd.rm_top = 1'b1;
            cmd.res    = imq_pkg::RES_OK_MEM;
            if (status.last_nonzero) begin
               cmd.a_rd  = 1'b1;
               cmd.a_sel = imq_pkg::ASEL_LAST;
               state_in  = ST_LAST_WT;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_LAST_WT: begin
            cmd.e_from_a = 1'b1;
            cmd.p_zero   = 1'b1;
            state_in     = ST_DN_RD;
         end
         ST_UP_RD: begin
            if (status.p_zero) begin
               cmd.place = 1'b1;
               state_in  = ST_FIN;
            end else begin
               cmd.a_rd  = 1'b1;
               cmd.a_sel = imq_pkg::ASEL_PARENT;
               state_in  = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (status.up_gt) begin
               cmd.up_move = 1'b1;
               state_in    = ST_UP_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_FIN;
            end
         end
         ST_DN_RD: begin
            if (status.left_out) begin
               cmd.place = 1'b1;
               state_in  = ST_FIN;
            end else begin
               cmd.a_rd  = 1'b1;
               cmd.a_sel = imq_pkg::ASEL_LEFT;
               cmd.b_rd  = 1'b1;
               state_in  = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (status.dn_lt) begin
               cmd.dn_move = 1'b1;
               state_in    = ST_DN_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_FIN;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/imq_datapath.sv */
// ---------------------------------------------------------------------------
// imq_datapath: heap storage and compare logic
// Heap slot memory, id-to-slot memory, presence bits, moving element,
// slot pointer, count and result register.
// ---------------------------------------------------------------------------
module imq_datapath #(
   parameter int CAPACITY = imq_pkg::CAPACITY_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  imq_pkg::cmd_type                      cmd,
   output imq_pkg::status_type                   status,
   input  logic [2:0]                            req_action,
   input  logic [imq_pkg::ID_WIDTH-1:0]          req_id,
   input  logic signed [imq_pkg::PRIO_WIDTH-1:0] req_priority_req,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_ok,
   output logic [imq_pkg::ID_WIDTH-1:0]          rsp_out_id,
   output logic signed [imq_pkg::PRIO_WIDTH-1:0] rsp_out_priority,
   output logic [imq_pkg::COUNT_WIDTH-1:0]       rsp_count
);

   // only ids reachable through the id field can ever be queued
   localparam int MAXID = 1 << imq_pkg::ID_WIDTH;
   localparam int NSLOT = (CAPACITY < MAXID) ? CAPACITY : MAXID;
   localparam int IW    = $clog2(NSLOT);
   localparam int SW    = $clog2(NSLOT);
   localparam int CW    = $clog2(NSLOT + 1);
   localparam int LW    = SW + 2;
   localparam int PW    = imq_pkg::PRIO_WIDTH;

   typedef logic [IW+PW-1:0] entry_type;

   entry_type heap_mem [NSLOT];
   logic [SW-1:0] pos_mem [NSLOT];

   logic [NSLOT-1:0] present_ff, present_in;
   logic [CW-1:0]    count_ff, count_in;

   logic [2:0]                   act_ff;
   logic [imq_pkg::ID_WIDTH-1:0] rid_ff;
   logic signed [PW-1:0]         rprio_ff;

   logic [IW-1:0]        e_id_ff;
   logic signed [PW-1:0] e_prio_ff;
   logic [SW-1:0]        p_ff;

   logic [SW-1:0]        pos_q_ff;
   logic [IW-1:0]        a_id_ff, b_id_ff;
   logic signed [PW-1:0] a_prio_ff, b_prio_ff;

   logic                         res_ok_ff;
   logic [imq_pkg::ID_WIDTH-1:0] res_id_ff;
   logic signed [PW-1:0]         res_prio_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_ok_ff;
   logic [imq_pkg::ID_WIDTH-1:0] rsp_id_ff;
   logic signed [PW-1:0]         rsp_prio_ff;
   logic [CW-1:0]                rsp_count_ff;

   logic                 id_ok;
   logic [IW-1:0]        rid_idx;
   logic [SW-1:0]        parent, last_slot, a_addr, right_slot, left_slot, big_slot;
   logic [LW-1:0]        left, right;
   logic                 right_in, pick_b;
   logic [IW-1:0]        big_id, w_id;
   logic signed [PW-1:0] big_prio, w_prio;
   logic                 heap_we;

   assign id_ok      = {1'b0, rid_ff} < (imq_pkg::ID_WIDTH + 1)'(NSLOT);
   assign rid_idx    = rid_ff[IW-1:0];
   assign parent     = SW'((p_ff - SW'(1)) >> 1);
   assign last_slot  = SW'(count_ff - CW'(1));
   assign left       = (LW'(p_ff) << 1) + LW'(1);
   assign right      = left + LW'(1);
   assign left_slot  = left[SW-1:0];
   assign right_slot = right[SW-1:0];
   assign right_in   = right < LW'(count_ff);
   assign pick_b     = right_in && (b_prio_ff > a_prio_ff);
   assign big_id     = pick_b ? b_id_ff : a_id_ff;
   assign big_prio   = pick_b ? b_prio_ff : a_prio_ff;
   assign big_slot   = pick_b ? right_slot : left_slot;

   always_comb begin
      case (cmd.a_sel)
         imq_pkg::ASEL_POS:    a_addr = pos_q_ff;
         imq_pkg::ASEL_LAST:   a_addr = last_slot;
         imq_pkg::ASEL_PARENT: a_addr = parent;
         imq_pkg::ASEL_LEFT:   a_addr = left_slot;
         default:              a_addr = '0;
      endcase
   end

   // hole-based sift: the moving element is written once, at its final slot
   always_comb begin
      heap_we = cmd.place | cmd.up_move | cmd.dn_move;
      if (cmd.place) begin
         w_id   = e_id_ff;
         w_prio = e_prio_ff;
      end else if (cmd.up_move) begin
         w_id   = a_id_ff;
         w_prio = a_prio_ff;
      end else begin
         w_id   = big_id;
         w_prio = big_prio;
      end
   end

   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_mem[p_ff] <= {w_id, w_prio};
         pos_mem[w_id]  <= p_ff;
      end
      if (cmd.a_rd) begin
         {a_id_ff, a_prio_ff} <= heap_mem[a_addr];
      end
      if (cmd.b_rd) begin
         {b_id_ff, b_prio_ff} <= heap_mem[right_slot];
      end
      if (cmd.pos_rd) begin
         pos_q_ff <= pos_mem[rid_idx];
      end
   end

   always_comb begin
      present_in = present_ff;
      count_in   = count_ff;
      if (cmd.ins_start) begin
         present_in[rid_idx] = 1'b1;
         count_in            = count_ff + CW'(1);
      end
      if (cmd.rm_top) begin
         present_in[a_id_ff] = 1'b0;
         count_in            = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         present_ff <= present_in;
         count_ff   <= count_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff   <= req_action;
         rid_ff   <= req_id;
         rprio_ff <= req_priority_req;
      end
      if (cmd.ins_start) begin
         e_id_ff   <= rid_idx;
         e_prio_ff <= rprio_ff;
         p_ff      <= SW'(count_ff);
      end else if (cmd.e_from_req) begin
         e_id_ff   <= rid_idx;
         e_prio_ff <= rprio_ff;
      end else if (cmd.e_from_a) begin
         e_id_ff   <= a_id_ff;
         e_prio_ff <= a_prio_ff;
      end
      if (cmd.latch_p_pos) begin
         p_ff <= pos_q_ff;
      end else if (cmd.p_zero) begin
         p_ff <= '0;
      end else if (cmd.up_move) begin
         p_ff <= parent;
      end else if (cmd.dn_move) begin
         p_ff <= big_slot;
      end
      case (cmd.res)
         imq_pkg::RES_FAIL: begin
            res_ok_ff   <= 1'b0;
            res_id_ff   <= (act_ff == imq_pkg::ACT_QUERY) ? rid_ff : '0;
            res_prio_ff <= '0;
         end
         imq_pkg::RES_OK_PLAIN: begin
            res_ok_ff   <= 1'b1;
            res_id_ff   <= '0;
            res_prio_ff <= '0;
         end
         imq_pkg::RES_OK_MEM: begin
            res_ok_ff   <= 1'b1;
            res_id_ff   <= imq_pkg::ID_WIDTH'(a_id_ff);
            res_prio_ff <= a_prio_ff;
         end
         default: ;
      endcase
      if (cmd.rsp_load) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_id_ff    <= res_id_ff;
         rsp_prio_ff  <= res_prio_ff;
         rsp_count_ff <= count_ff;
      end
   end

   always_comb begin
      status.act          = act_ff;
      status.id_ok        = id_ok;
      status.present      = id_ok && present_ff[rid_idx];
      status.count_zero   = (count_ff == '0);
      status.count_full   = (count_ff == CW'(NSLOT));
      status.last_nonzero = (count_ff > CW'(1));
      status.p_zero       = (p_ff == '0);
      status.left_out     = !(left < LW'(count_ff));
      status.up_gt        = e_prio_ff > a_prio_ff;
      status.dn_lt        = e_prio_ff < big_prio;
      status.inc_ok       = rprio_ff > a_prio_ff;
      status.dec_ok       = rprio_ff < a_prio_ff;
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_out_id       = rsp_id_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_count        = imq_pkg::COUNT_WIDTH'(rsp_count_ff);

endmodule

/* hw/rtl/indexed_max_priority_queue_unit.sv */
// ---------------------------------------------------------------------------
// indexed_max_priority_queue_unit: indexed binary max-heap
// Insert, increase, decrease, remove-max and query over ids, one result
// per request.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | action, id, priority_req
//  rsp     | out       | rsp_valid/rsp_ready  | ok, out_id, out_priority, count
//
//  One request at a time. Each request is decoded and then its result formed;
//  insert adds a sift up, query a position read and a slot read, change those
//  reads plus a sift, remove a top read and, if more remain, a last-slot read
//  and a sift down. Each sift level does a registered memory read, then a compare and move.
//  Reset clears count and presence bits directly; no clearing pass.
//  A waiting result does not block the next request's transfer.
module indexed_max_priority_queue_unit #(
   parameter int CAPACITY = imq_pkg::CAPACITY_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [2:0]                            req_action,
   input  logic [imq_pkg::ID_WIDTH-1:0]          req_id,
   input  logic signed [imq_pkg::PRIO_WIDTH-1:0] req_priority_req,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_ok,
   output logic [imq_pkg::ID_WIDTH-1:0]          rsp_out_id,
   output logic signed [imq_pkg::PRIO_WIDTH-1:0] rsp_out_priority,
   output logic [imq_pkg::COUNT_WIDTH-1:0]       rsp_count
);

   imq_pkg::cmd_type    cmd;
   imq_pkg::status_type status;

   imq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   imq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_action),
      .req_id           (req_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ok           (rsp_ok),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_priority (rsp_out_priority),
      .rsp_count        (rsp_count)
   );

   a_no_up_past_root: assert property (@(posedge clock) disable iff (reset)
      cmd.up_move |-> !status.p_zero)
      else $error("sift-up moved past the root");

   a_remove_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.rm_top |-> !status.count_zero)
      else $error("remove on empty heap");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= imq_pkg::COUNT_WIDTH'(CAPACITY)
                     || CAPACITY > 64))
      else $error("count above capacity");

endmodule
